// ----- hdl/sbs_pkg.sv -----
package sbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } result_t;

endpackage

// ----- hdl/sbs_table.sv -----
module sbs_table #(
    parameter int DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [sbs_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [sbs_pkg::DATA_W-1:0] rd_data
);

    logic [sbs_pkg::DATA_W-1:0] mem [DEPTH];
    logic [sbs_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/sbs_ctrl.sv -----
module sbs_ctrl #(
    parameter int DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int NW    = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic signed [sbs_pkg::DATA_W-1:0] key,
    input  logic [sbs_pkg::COUNT_W-1:0]       count,
    output logic                              rd_en,
    output logic [AW-1:0]                     rd_addr,
    input  logic signed [sbs_pkg::DATA_W-1:0] rd_data,
    output logic                              busy,
    output logic                              done,
    output sbs_pkg::result_t                  result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [NW-1:0]                     lo_reg, lo_next;
    logic [NW-1:0]                     lim_reg, lim_next;
    logic [AW-1:0]                     mid_reg, mid_next;
    logic signed [sbs_pkg::DATA_W-1:0] key_reg, key_next;
    logic                              done_reg, done_next;
    sbs_pkg::result_t                  res_reg, res_next;

    logic [NW-1:0] count_clamped;
    logic [NW:0]   mid_sum;
    logic [AW-1:0] mid;
    logic          range_open;

    // counts above the table depth search the whole table
    assign count_clamped = (32'(count) > 32'(DEPTH)) ? NW'(DEPTH) : NW'(count);

    // lim is one past the high bound, so mid = (lo + lim - 1) / 2
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, lim_reg} - (NW+1)'(1);
    assign mid        = AW'(mid_sum >> 1);
    assign range_open = lo_reg < lim_reg;

    assign rd_en   = (state_reg == ST_PROBE) && range_open;
    assign rd_addr = mid;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        lim_next   = lim_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    lo_next    = '0;
                    lim_next   = count_clamped;
                    key_next   = key;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (range_open)
                begin
                    mid_next   = mid;
                    state_next = ST_CMP;
                end
                else
                begin
                    done_next         = 1'b1;
                    res_next.found    = 1'b0;
                    res_next.position = '0;
                    state_next        = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    done_next         = 1'b1;
                    res_next.found    = 1'b1;
                    res_next.position = sbs_pkg::INDEX_W'(mid_reg);
                    state_next        = ST_IDLE;
                end
                else if (rd_data < key_reg)
                begin
                    lo_next    = NW'(mid_reg) + NW'(1);
                    state_next = ST_PROBE;
                end
                else
                begin
                    lim_next   = NW'(mid_reg);
                    state_next = ST_PROBE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        lim_reg <= lim_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
// sorted table with halving search
//
// command channel: drive req_type and its fields with start high; the item is
// taken on a clock edge where start is high and busy is low.
// a load (req_type 0) writes element_value at load_index in that same edge,
// gives no result and leaves busy low, so loads can go every cycle. a load
// with load_index beyond the table depth is dropped.
// a search (req_type 1) raises busy and probes one midpoint at a time through
// the table's single read port: the probe state reads the table and the compare
// state compares and moves a bound. a search makes at most ceil(log2(count + 1))
// probes (11 for a full 1024-entry table). the result comes as a one-cycle done
// beat with found and position; the receiver cannot hold it off, and busy is
// already low in that cycle.
// element_count is written over cfg_valid / cfg_ready / cfg_data; cfg_ready
// is high whenever no search is running.
// reset clears element_count and the sequencer; table contents are undefined
// until loaded.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [sbs_pkg::INDEX_W-1:0]       load_index,
    input  logic signed [sbs_pkg::DATA_W-1:0] element_value,
    input  logic signed [sbs_pkg::DATA_W-1:0] search_key,
    output logic                              done,
    output logic                              found,
    output logic [sbs_pkg::INDEX_W-1:0]       position,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbs_pkg::COUNT_W-1:0]       cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    logic [sbs_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                              accept;
    logic                              wr_en;
    logic                              go;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [sbs_pkg::DATA_W-1:0] rd_data;
    sbs_pkg::result_t                  result;

    assign accept = start && !busy;
    assign go     = accept && (req_type == sbs_pkg::REQ_SEARCH);
    assign wr_en  = accept && (req_type == sbs_pkg::REQ_LOAD)
                    && (32'(load_index) < 32'(TABLE_DEPTH));

    assign cfg_ready = !busy;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    sbs_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(load_index)),
        .wr_data (element_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbs_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .NW    (NW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .key     (search_key),
        .count   (count_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    assign found    = result.found;
    assign position = result.position;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("miss reported with nonzero position");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == sbs_pkg::REQ_SEARCH)) |=> busy)
        else $error("search accepted without going busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == sbs_pkg::REQ_LOAD)) |=> (!busy && !done))
        else $error("load started a search or gave a result");

endmodule

// ----- sim/tb_sorted_table_binary_search.sv -----
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;

    localparam int TABLE_DEPTH  = sbs_pkg::DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 300;
    localparam logic signed [sbs_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sbs_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              req_type;
    logic [sbs_pkg::INDEX_W-1:0]       load_index;
    logic signed [sbs_pkg::DATA_W-1:0] element_value;
    logic signed [sbs_pkg::DATA_W-1:0] search_key;
    logic                              done;
    logic                              found;
    logic [sbs_pkg::INDEX_W-1:0]       position;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [sbs_pkg::COUNT_W-1:0]       cfg_data;

    // shadow of the table and the count register
    logic signed [sbs_pkg::DATA_W-1:0] entry_mem [TABLE_DEPTH];
    bit                                entry_written [TABLE_DEPTH];
    logic [sbs_pkg::COUNT_W-1:0]       live_count;

    sbs_pkg::result_t pending_lookups [$];
    sbs_pkg::result_t lookup_want;
    int               fail_count;
    int               burst_left;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .load_index    (load_index),
        .element_value (element_value),
        .search_key    (search_key),
        .done          (done),
        .found         (found),
        .position      (position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // halving search over the shadow table, count clamped to the depth
    function automatic sbs_pkg::result_t lookup_expected(
        input logic signed [sbs_pkg::DATA_W-1:0] key);
        sbs_pkg::result_t r;
        int               n;
        int               lo;
        int               hi;
        int               mid;
        r  = '0;
        n  = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (entry_mem[mid] == key)
            begin
                r.found    = 1'b1;
                r.position = sbs_pkg::INDEX_W'(mid);
                break;
            end
            else if (entry_mem[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return r;
    endfunction

    // first entry on the probe path that was never loaded, -1 if none
    function automatic int first_unwritten_probe(
        input logic signed [sbs_pkg::DATA_W-1:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        n  = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (!entry_written[mid])
                return mid;
            if (entry_mem[mid] == key)
                return -1;
            else if (entry_mem[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    // strictly ascending fill from the most negative value, in steps of 2**22
    function automatic logic signed [sbs_pkg::DATA_W-1:0] ramp_value(input int i);
        return {sbs_pkg::INDEX_W'(i), 22'd0} ^ 32'h8000_0000;
    endfunction

    task automatic send_item(input logic req, input logic [sbs_pkg::INDEX_W-1:0] idx,
                             input logic signed [sbs_pkg::DATA_W-1:0] val,
                             input logic signed [sbs_pkg::DATA_W-1:0] key);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        start         <= 1'b1;
        req_type      <= req;
        load_index    <= idx;
        element_value <= val;
        search_key    <= key;
        do
            @(posedge clk);
        while (busy);
        if (req == sbs_pkg::REQ_LOAD)
        begin
            entry_mem[idx]     = val;
            entry_written[idx] = 1'b1;
        end
        else
            pending_lookups.push_back(lookup_expected(key));
    endtask

    task automatic load_entry(input logic [sbs_pkg::INDEX_W-1:0] idx,
                              input logic signed [sbs_pkg::DATA_W-1:0] val);
        send_item(sbs_pkg::REQ_LOAD, idx, val, $urandom);
    endtask

    task automatic search_for(input logic signed [sbs_pkg::DATA_W-1:0] key);
        int hole;
        // never let a search probe an entry that holds nothing yet
        hole = first_unwritten_probe(key);
        while (hole >= 0)
        begin
            load_entry(sbs_pkg::INDEX_W'(hole), ramp_value(hole));
            hole = first_unwritten_probe(key);
        end
        send_item(sbs_pkg::REQ_SEARCH, sbs_pkg::INDEX_W'($urandom), $urandom, key);
    endtask

    task automatic write_element_count(input logic [sbs_pkg::COUNT_W-1:0] count);
        @(negedge clk);
        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do
            @(posedge clk);
        while (!cfg_ready);
        live_count = count;
        @(negedge clk);
        cfg_valid  <= 1'b0;
        burst_left = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("result beat with no search outstanding: found %0d position %0d",
                       found, position);
                fail_count++;
            end
            else
            begin
                lookup_want = pending_lookups.pop_front();
                if (found !== lookup_want.found)
                begin
                    $error("found: expected %0d, got %0d", lookup_want.found, found);
                    fail_count++;
                end
                if (position !== lookup_want.position)
                begin
                    $error("position: expected %0d, got %0d", lookup_want.position, position);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_count_zero();
        search_for(32'sd0);
        write_element_count(11'd0);
        search_for(VAL_MAX);
        search_for(VAL_MIN);
    endtask

    task automatic test_extreme_values();
        load_entry(10'd0, VAL_MIN);
        load_entry(10'd1, -32'sd1);
        load_entry(10'd2, 32'sd0);
        load_entry(10'd3, 32'sd1);
        load_entry(10'd4, VAL_MAX);
        write_element_count(11'd5);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
        search_for(32'sd0);
        search_for(-32'sd1);
        search_for(32'sd1);
        search_for(32'sd2);
        search_for(VAL_MIN + 32'sd1);
        search_for(VAL_MAX - 32'sd1);
    endtask

    task automatic test_duplicates();
        for (int i = 0; i < 4; i++)
            load_entry(sbs_pkg::INDEX_W'(i), 32'sd7);
        load_entry(10'd4, 32'sd9);
        load_entry(10'd5, 32'sd9);
        write_element_count(11'd6);
        search_for(32'sd7);
        search_for(32'sd9);
        search_for(32'sd8);
    endtask

    task automatic test_unsorted();
        for (int i = 0; i < 5; i++)
            load_entry(sbs_pkg::INDEX_W'(i), 32'(50 - 10 * i));
        write_element_count(11'd5);
        search_for(32'sd30);
        search_for(32'sd10);
        search_for(32'sd50);
    endtask

    task automatic test_full_table();
        // low entries back on the ramp, the rest is filled along the probe paths
        for (int i = 0; i < 8; i++)
            load_entry(sbs_pkg::INDEX_W'(i), ramp_value(i));
        write_element_count(11'd1024);
        search_for(ramp_value(0));
        search_for(ramp_value(TABLE_DEPTH - 1));
        search_for(ramp_value(511));
        search_for(ramp_value(700) + 32'sd1);
        search_for(VAL_MAX);
        // count above the depth is clamped
        write_element_count(11'd2047);
        search_for(ramp_value(TABLE_DEPTH - 1));
        search_for(ramp_value(3));
        write_element_count(11'd1);
        search_for(ramp_value(0));
        search_for(ramp_value(1));
    endtask

    task automatic test_random_tables();
        int sent;
        int n;
        int n_eff;
        int pick;
        int loaded;
        int spread;
        int base;
        int k;
        int vals [$];
        logic signed [sbs_pkg::DATA_W-1:0] key;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = 0;
            else if (pick == 1)
                n = $urandom_range(TABLE_DEPTH + 1, 2047);
            else if (pick == 2)
                n = $urandom_range(100, 300);
            else
                n = $urandom_range(1, 32);
            n_eff  = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            loaded = n_eff;
            // now and then, and whenever the count exceeds the depth, keep the old contents and only move the count
            if ($urandom_range(0, 9) == 0 || n > TABLE_DEPTH)
                loaded = 0;
            vals.delete();
            spread = $urandom_range(0, 2);
            base   = $urandom;
            for (int i = 0; i < loaded; i++)
                vals.push_back((spread == 0) ? base + $urandom_range(0, n / 2) : $urandom);
            vals.sort();
            for (int i = 0; i < loaded; i++)
            begin
                load_entry(sbs_pkg::INDEX_W'(i), vals[i]);
                sent++;
            end
            write_element_count(sbs_pkg::COUNT_W'(n));
            repeat ($urandom_range(3, 20))
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    load_entry(sbs_pkg::INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                               $urandom);
                else
                begin
                    k = (n_eff == 0) ? 0 : $urandom_range(0, n_eff - 1);
                    if (n_eff == 0 || pick == 1)
                        key = $urandom;
                    else if (pick == 2)
                        key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
                    else if (!entry_written[k])
                        key = $urandom;
                    else if (pick == 3)
                        key = entry_mem[k] + ($urandom_range(0, 1) ? 1 : -1);
                    else
                        key = entry_mem[k];
                    search_for(key);
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        int waited;
        rst_n         = 1'b0;
        start         = 1'b0;
        req_type      = sbs_pkg::REQ_LOAD;
        load_index    = '0;
        element_value = '0;
        search_key    = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        live_count    = '0;
        fail_count    = 0;
        burst_left    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_count_zero();
        test_extreme_values();
        test_duplicates();
        test_unsorted();
        test_full_table();
        test_random_tables();

        @(negedge clk);
        start  <= 1'b0;
        waited = 0;
        while (pending_lookups.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (pending_lookups.size() != 0)
        begin
            $error("%0d search results never arrived", pending_lookups.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
